// File: hw/rtl/gki_pkg.sv
// gki_pkg: shared constants for the grid kernel inflation block
// function and status codes, field widths, register indexes and reset values
// no dependencies
package gki_pkg;

  // default sizes
  localparam int DEF_MAX_CELLS       = 131072;
  localparam int DEF_MAX_KERNEL_SIDE = 15;
  localparam int DEF_COST_WINDOW     = 5;

  // field widths
  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 17;
  localparam int SLOT_W  = 8;
  localparam int VAL_W   = 7;
  localparam int STAT_W  = 2;
  localparam int COLS_W  = 10;
  localparam int ROWS_W  = 9;
  localparam int RAD_W   = 3;

  // configuration port
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 10;

  // signed row, column and cell offsets during a window scan
  localparam int RC_W    = 19;

  // row split divider widths
  localparam int DIVD_W  = IDX_W;
  localparam int DIVS_W  = COLS_W;

  localparam int VAL_MAX = 100;

  // function codes
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STAMP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_COST  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_RADIUS  = 2'd2;

  // register reset values
  localparam logic [COLS_W-1:0] RST_COLUMNS = 10'd320;
  localparam logic [ROWS_W-1:0] RST_ROWS    = 9'd160;
  localparam logic [RAD_W-1:0]  RST_RADIUS  = 3'd4;

endpackage

// File: hw/rtl/gki_ram.sv
// gki_ram: simple dual port synchronous memory, one write and one read port
// read data registered; uses gki_pkg for defaults
module gki_ram #(
  parameter int DEPTH = gki_pkg::DEF_MAX_CELLS,
  parameter int WIDTH = gki_pkg::VAL_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/gki_div.sv
// gki_div: restoring divider, one quotient bit per cycle
// splits a cell index into row and column by the column count; uses gki_pkg
module gki_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [gki_pkg::DIVD_W-1:0] dividend,
  input  logic [gki_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [gki_pkg::DIVD_W-1:0] quot,
  output logic [gki_pkg::DIVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(gki_pkg::DIVD_W);

  logic                       running;
  logic [CNT_W-1:0]           cnt;
  logic [gki_pkg::DIVS_W-1:0] dsr;
  logic [gki_pkg::DIVS_W:0]   trial;
  logic [gki_pkg::DIVS_W:0]   diff;
  logic                       fits;

  assign trial = {rem, quot[gki_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(gki_pkg::DIVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (go) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (running) begin
      quot <= {quot[gki_pkg::DIVD_W-2:0], fits};
      rem  <= fits ? diff[gki_pkg::DIVS_W-1:0] : trial[gki_pkg::DIVS_W-1:0];
    end
  end

endmodule

// File: hw/rtl/grid_kernel_inflation_top.sv
// grid_kernel_inflation_top: occupancy grid with square kernel inflation
// holds the grid and kernel memories, the sequencer and the config registers
// uses gki_pkg, gki_ram and gki_div
//
// load and a bad func answer straight from idle; clear sweeps every grid cell;
// stamp walks a (2r+1)^2 window with r the clipped radius, cost a COST_WINDOW^2 one;
// one transaction at a time: a 17-step serial row split of
// cell_index, then one window position per cycle through the single grid port
// after reset both memories sweep to zero with busy high;
// config writes taken throughout; results strobe on done, no stall
module grid_kernel_inflation_top #(
  parameter int MAX_CELLS       = gki_pkg::DEF_MAX_CELLS,
  parameter int MAX_KERNEL_SIDE = gki_pkg::DEF_MAX_KERNEL_SIDE,
  parameter int COST_WINDOW     = gki_pkg::DEF_COST_WINDOW
) (
  input  logic                       clk,
  input  logic                       rst,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic [gki_pkg::FUNC_W-1:0] func,
  input  logic [gki_pkg::IDX_W-1:0]  cell_index,
  input  logic [gki_pkg::SLOT_W-1:0] kernel_slot,
  input  logic [gki_pkg::VAL_W-1:0]  kernel_value,
  // result channel
  output logic                       done,
  output logic [gki_pkg::VAL_W-1:0]  value,
  output logic [gki_pkg::STAT_W-1:0] status,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gki_pkg::CFG_IW-1:0] cfg_index,
  input  logic [gki_pkg::CFG_DW-1:0] cfg_data
);

  localparam int CELL_AW = $clog2(MAX_CELLS);
  localparam int KTAB    = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
  localparam int KAW     = $clog2(KTAB);
  localparam int KRMAX   = (MAX_KERNEL_SIDE - 1) / 2;
  localparam int CB      = COST_WINDOW / 2;
  localparam int MAXR    = (KRMAX > CB) ? KRMAX : CB;
  localparam int SCW     = $clog2(2 * MAXR + 1);
  localparam int SWEEP_N = (MAX_CELLS > KTAB) ? MAX_CELLS : KTAB;
  localparam int SWW     = $clog2(SWEEP_N);
  localparam int WIN_N   = COST_WINDOW * COST_WINDOW;
  localparam int SUM_W   = $clog2(WIN_N * gki_pkg::VAL_MAX + 1);
  localparam int RC_W    = gki_pkg::RC_W;
  localparam int VAL_W   = gki_pkg::VAL_W;

  // window mean as sum * ceil(2^MEAN_SH / WIN_N) >> MEAN_SH, exact for every reachable sum
  localparam int MEAN_SH = SUM_W + $clog2(WIN_N);
  localparam int MEAN_M  = ((1 << MEAN_SH) + WIN_N - 1) / WIN_N;
  localparam int MEAN_MW = $clog2(MEAN_M + 1);
  localparam int PROD_W  = SUM_W + MEAN_MW;

  // sequencer states
  localparam logic [3:0] S_SWEEP = 4'd0;  // power-on clear of both memories
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;  // cell_index / columns
  localparam logic [3:0] S_CHECK = 4'd3;  // bounds test, scan setup
  localparam logic [3:0] S_SCAN  = 4'd4;  // one window position per cycle
  localparam logic [3:0] S_DRAIN = 4'd5;  // last read returns
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;  // single cell read
  localparam logic [3:0] S_CLEAR = 4'd9;  // grid clear sweep

  logic [3:0] state;

  // configuration registers
  logic [gki_pkg::COLS_W-1:0] grid_columns;
  logic [gki_pkg::ROWS_W-1:0] grid_rows;
  logic [gki_pkg::RAD_W-1:0]  kernel_radius;

  // item registers
  logic [gki_pkg::FUNC_W-1:0] op;
  logic [gki_pkg::IDX_W-1:0]  idx_r;

  // scan registers
  logic [SCW-1:0]         two_r;
  logic [SCW-1:0]         i_cnt;
  logic [SCW-1:0]         j_cnt;
  logic signed [RC_W-1:0] trow;
  logic signed [RC_W-1:0] tcol;
  logic signed [RC_W-1:0] tcol0;
  logic signed [RC_W-1:0] ix;
  logic signed [RC_W-1:0] row_ix;
  logic [KAW-1:0]         kslot;
  logic [SUM_W-1:0]       sum;
  logic [SWW-1:0]         sw_cnt;

  // read-return stage
  logic               p_valid;
  logic               p_inb;
  logic [CELL_AW-1:0] p_addr;

  // output registers
  logic               done_r;
  logic [VAL_W-1:0]   value_r;
  logic [gki_pkg::STAT_W-1:0] status_r;

  // memory ports
  logic               g_we;
  logic [CELL_AW-1:0] g_waddr;
  logic [VAL_W-1:0]   g_wdata;
  logic [CELL_AW-1:0] g_raddr;
  logic [VAL_W-1:0]   g_rdata;
  logic               k_we;
  logic [KAW-1:0]     k_waddr;
  logic [VAL_W-1:0]   k_wdata;
  logic [VAL_W-1:0]   k_rdata;

  // divider
  logic                       div_go;
  logic [gki_pkg::DIVD_W-1:0] div_dividend;
  logic [gki_pkg::DIVS_W-1:0] div_divisor;
  logic                       div_done;
  logic [gki_pkg::DIVD_W-1:0] div_quot;
  logic [gki_pkg::DIVS_W-1:0] div_rem;

  // combinational helpers
  logic                       accept;
  logic [gki_pkg::COLS_W-1:0] eff_cols;
  logic [gki_pkg::ROWS_W-1:0] eff_rows;
  logic signed [RC_W-1:0]     cols_s;
  logic signed [RC_W-1:0]     rows_s;
  logic [SCW-1:0]             r_eff;
  logic [SCW-1:0]             r_c;
  logic signed [RC_W-1:0]     r_s;
  logic [RC_W-1:0]            r_cols;
  logic signed [RC_W-1:0]     ix0;
  logic                       inside_c;
  logic                       inb_c;
  logic                       slot_ok;
  logic [VAL_W-1:0]           kval_sat;
  logic                       sweep_grid;
  logic                       sweep_kern;
  logic                       stamp_we;
  logic [PROD_W-1:0]          mean_prod;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign done      = done_r;
  assign value     = value_r;
  assign status    = status_r;

  // zero columns or rows behave as one
  assign eff_cols = (grid_columns == '0) ? gki_pkg::COLS_W'(1) : grid_columns;
  assign eff_rows = (grid_rows == '0) ? gki_pkg::ROWS_W'(1) : grid_rows;
  assign cols_s   = $signed(RC_W'(eff_cols));
  assign rows_s   = $signed(RC_W'(eff_rows));

  // kernel radius clipped to the stored kernel side
  assign r_eff = (32'(kernel_radius) > KRMAX) ? SCW'(KRMAX) : SCW'(kernel_radius);
  assign r_c   = (op == gki_pkg::FN_STAMP) ? r_eff : SCW'(CB);
  assign r_s   = $signed(RC_W'(r_c));

  // top-left cell index of the window, may be negative
  assign r_cols = RC_W'(r_c) * RC_W'(eff_cols);
  assign ix0    = $signed(RC_W'(idx_r)) - $signed(r_cols) - r_s;

  assign inside_c = (32'(idx_r) < 32'(MAX_CELLS)) &&
                    (div_quot < gki_pkg::DIVD_W'(eff_rows));

  // position in the grid, no wrap across a row edge
  assign inb_c = (trow >= 0) && (trow < rows_s) && (tcol >= 0) && (tcol < cols_s) &&
                 (32'(ix) < 32'(MAX_CELLS));

  assign slot_ok  = (32'(kernel_slot) < 32'(KTAB));
  assign kval_sat = (kernel_value > VAL_W'(gki_pkg::VAL_MAX)) ?
                    VAL_W'(gki_pkg::VAL_MAX) : kernel_value;

  // truncated window mean
  assign mean_prod = PROD_W'(sum) * PROD_W'(MEAN_M);

  // memory write port selection
  assign sweep_grid = ((state == S_SWEEP) && (32'(sw_cnt) < 32'(MAX_CELLS))) ||
                      (state == S_CLEAR);
  assign sweep_kern = (state == S_SWEEP) && (32'(sw_cnt) < 32'(KTAB));
  assign stamp_we   = p_valid && p_inb && (op == gki_pkg::FN_STAMP) &&
                      (k_rdata != '0) && (g_rdata < k_rdata);

  assign g_we    = sweep_grid || stamp_we;
  assign g_waddr = sweep_grid ? CELL_AW'(sw_cnt) : p_addr;
  assign g_wdata = sweep_grid ? '0 : k_rdata;
  assign g_raddr = (state == S_SCAN) ? CELL_AW'(ix) : CELL_AW'(idx_r);

  assign k_we    = sweep_kern ||
                   (accept && (func == gki_pkg::FN_LOAD) && slot_ok);
  assign k_waddr = sweep_kern ? KAW'(sw_cnt) : KAW'(kernel_slot);
  assign k_wdata = sweep_kern ? '0 : kval_sat;

  // divider: row split on accept
  assign div_go = accept && ((func == gki_pkg::FN_STAMP) || (func == gki_pkg::FN_COST) ||
                             (func == gki_pkg::FN_READ));
  assign div_dividend = cell_index;
  assign div_divisor  = eff_cols;

  gki_ram #(
    .DEPTH (MAX_CELLS),
    .WIDTH (VAL_W)
  ) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  gki_ram #(
    .DEPTH (KTAB),
    .WIDTH (VAL_W)
  ) u_kern (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (kslot),
    .rdata (k_rdata)
  );

  gki_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns  <= gki_pkg::RST_COLUMNS;
      grid_rows     <= gki_pkg::RST_ROWS;
      kernel_radius <= gki_pkg::RST_RADIUS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gki_pkg::CFG_COLUMNS: grid_columns  <= cfg_data[gki_pkg::COLS_W-1:0];
        gki_pkg::CFG_ROWS:    grid_rows     <= cfg_data[gki_pkg::ROWS_W-1:0];
        gki_pkg::CFG_RADIUS:  kernel_radius <= cfg_data[gki_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      sw_cnt  <= '0;
      done_r  <= 1'b0;
      p_valid <= 1'b0;
      i_cnt   <= '0;
      j_cnt   <= '0;
    end else begin
      done_r  <= 1'b0;
      p_valid <= (state == S_SCAN);
      case (state)
        S_SWEEP: begin
          sw_cnt <= sw_cnt + SWW'(1);
          if (sw_cnt == SWW'(SWEEP_N - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (func) inside
              gki_pkg::FN_CLEAR: begin
                sw_cnt <= '0;
                state  <= S_CLEAR;
              end
              gki_pkg::FN_LOAD: begin
                done_r   <= 1'b1;
                value_r  <= '0;
                status_r <= slot_ok ? gki_pkg::ST_DONE : gki_pkg::ST_BAD;
              end
              gki_pkg::FN_STAMP, gki_pkg::FN_COST, gki_pkg::FN_READ: begin
                state <= S_DIV;
              end
              default: begin
                done_r   <= 1'b1;
                value_r  <= '0;
                status_r <= gki_pkg::ST_BAD;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!inside_c) begin
            done_r   <= 1'b1;
            value_r  <= '0;
            status_r <= gki_pkg::ST_OUTSIDE;
            state    <= S_IDLE;
          end else if (op == gki_pkg::FN_READ) begin
            state <= S_RD;
          end else begin
            i_cnt <= '0;
            j_cnt <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (j_cnt == two_r) begin
            j_cnt <= '0;
            i_cnt <= i_cnt + SCW'(1);
            if (i_cnt == two_r) begin
              state <= S_DRAIN;
            end
          end else begin
            j_cnt <= j_cnt + SCW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          done_r   <= 1'b1;
          value_r  <= (op == gki_pkg::FN_COST) ? VAL_W'(mean_prod >> MEAN_SH) : '0;
          status_r <= gki_pkg::ST_DONE;
          state    <= S_IDLE;
        end
        S_RD: begin
          done_r   <= 1'b1;
          value_r  <= g_rdata;
          status_r <= gki_pkg::ST_DONE;
          state    <= S_IDLE;
        end
        S_CLEAR: begin
          sw_cnt <= sw_cnt + SWW'(1);
          if (sw_cnt == SWW'(MAX_CELLS - 1)) begin
            done_r   <= 1'b1;
            value_r  <= '0;
            status_r <= gki_pkg::ST_DONE;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // scan datapath: window position, cell index and kernel slot step together
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      op    <= func;
      idx_r <= cell_index;
    end

    if (state == S_CHECK) begin
      two_r  <= SCW'({r_c, 1'b0});
      trow   <= $signed(RC_W'(div_quot)) - r_s;
      tcol   <= $signed(RC_W'(div_rem)) - r_s;
      tcol0  <= $signed(RC_W'(div_rem)) - r_s;
      ix     <= ix0;
      row_ix <= ix0;
      kslot  <= '0;
      sum    <= '0;
    end else if (state == S_SCAN) begin
      if (j_cnt == two_r) begin
        // next kernel row
        trow   <= trow + RC_W'(1);
        tcol   <= tcol0;
        row_ix <= row_ix + cols_s;
        ix     <= row_ix + cols_s;
        kslot  <= kslot + KAW'(MAX_KERNEL_SIDE) - KAW'(two_r);
      end else begin
        tcol  <= tcol + RC_W'(1);
        ix    <= ix + RC_W'(1);
        kslot <= kslot + KAW'(1);
      end
    end

    // read return: window sum for the cost query
    if (p_valid && p_inb && (op == gki_pkg::FN_COST)) begin
      sum <= sum + SUM_W'(g_rdata);
    end

    p_inb  <= inb_c;
    p_addr <= CELL_AW'(ix);
  end

endmodule
